@@ sv/ttq_pkg.sv @@
// ----------------------------------------------------------------------------
// Timer task heap scheduler package
// Widths, operation codes, status codes and shared types of the timer queue.
// ----------------------------------------------------------------------------
package ttq_pkg;

	localparam int OP_W       = 3;
	localparam int ID_W       = 8;
	localparam int TIME_W     = 63;
	localparam int CNT_W      = 9;
	localparam int ST_W       = 3;
	localparam int POS_W      = 10;
	localparam int TASK_SLOTS = 256;
	localparam int MAX_TASKS_DEF = 256;
	localparam int IN_W       = 208;
	localparam int OUT_W      = 152;

	// Operation codes of an input transaction.
	typedef enum logic [OP_W-1:0] {
		OP_SCHEDULE = 3'd0,
		OP_POLL     = 3'd1,
		OP_CANCEL   = 3'd2,
		OP_PURGE    = 3'd3,
		OP_CANCEL_T = 3'd4
	} op_t;

	// Result status codes.
	typedef enum logic [ST_W-1:0] {
		ST_DONE     = 3'd0,
		ST_FIRED    = 3'd1,
		ST_NOTDUE   = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_BADARG   = 3'd4,
		ST_BADSTATE = 3'd5,
		ST_FULL     = 3'd6
	} status_t;

	// Per-task life cycle.
	typedef enum logic [1:0] {
		TS_FRESH    = 2'd0,
		TS_SCHED    = 2'd1,
		TS_CANCEL   = 2'd2,
		TS_FINISHED = 2'd3
	} tstat_t;

	// Where the sequencer goes once a heap insert or delete completes.
	typedef enum logic [2:0] {
		RET_SCHED    = 3'd0,
		RET_POLLDROP = 3'd1,
		RET_POLLFIRE = 3'd2,
		RET_PURGE    = 3'd3,
		RET_REINS    = 3'd4
	} ret_t;

	// Write controls of the task table.
	typedef struct packed {
		logic                  due_we;
		logic                  cfg_we;
		logic                  stat_we;
		logic [ID_W-1:0]       waddr;
		logic [TIME_W-1:0]     due;
		logic [TIME_W-1:0]     period;
		logic                  fixed;
		tstat_t                stat;
	} task_wr_t;

	// Read data of the task table.
	typedef struct packed {
		logic [TIME_W-1:0]     due;
		logic [TIME_W-1:0]     period;
		logic                  fixed;
		tstat_t                stat;
	} task_rd_t;

endpackage

@@ sv/timer_task_heap_scheduler.sv @@
// ----------------------------------------------------------------------------
// Timer task heap scheduler
// Timer queue holding task ids in a binary min-heap ordered by due time.
// ----------------------------------------------------------------------------
// Usage: each input transaction on s_axis carries one command (schedule,
// poll, cancel task, purge, cancel timer) and produces exactly one result
// transaction on m_axis. A command is taken only while the sequencer is idle;
// s_axis_tready stays low while it works. Each heap step reads the heap memory
// and then the task table through registered ports. A schedule sifts the new
// task up; a poll that fires and requeues its task deletes the top, sifting
// down and up, and then sifts the requeued task up; a purge walks the whole
// heap entry by entry, plus one delete per removed task.
// The result sits in an output register, so the next command is accepted
// while it waits; if m_axis_tready stays low, the next result waits for the
// register to drain. Reset (arst_n low) empties the heap, marks every task
// fresh and clears the cancelled-timer flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module timer_task_heap_scheduler
	import ttq_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// opcode[2:0], task_id[10:3], now[73:11], delay[136:74], period[199:137],
	// fixed_rate[200], zero fill up to bit 207
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// status[2:0], fired_task[10:3], fire_time[73:11], wait_time[136:74],
	// count[145:137], zero fill up to bit 151
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	typedef enum logic [23:0] {
		S_IDLE      = 24'd1 << 0,
		S_DISP      = 24'd1 << 1,
		S_SCH_CHK   = 24'd1 << 2,
		S_POLL_TOP  = 24'd1 << 3,
		S_POLL_ID   = 24'd1 << 4,
		S_POLL_ST   = 24'd1 << 5,
		S_POLL_RE   = 24'd1 << 6,
		S_PURGE_CHK = 24'd1 << 7,
		S_PURGE_ID  = 24'd1 << 8,
		S_PURGE_ST  = 24'd1 << 9,
		S_DEL_START = 24'd1 << 10,
		S_DEL_ID    = 24'd1 << 11,
		S_DEL_DUE   = 24'd1 << 12,
		S_UP_CHK    = 24'd1 << 13,
		S_UP_PID    = 24'd1 << 14,
		S_UP_CMP    = 24'd1 << 15,
		S_DN_CHK    = 24'd1 << 16,
		S_DN_C1     = 24'd1 << 17,
		S_DN_D1     = 24'd1 << 18,
		S_DN_C2     = 24'd1 << 19,
		S_DN_D2     = 24'd1 << 20,
		S_DN_CMP    = 24'd1 << 21,
		S_FIN       = 24'd1 << 22,
		S_RESULT    = 24'd1 << 23
	} state_t;

	state_t state_q;

	// Latched command.
	logic [OP_W-1:0]   op_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] delay_q;
	logic [TIME_W-1:0] period_q;
	logic              fixed_q;

	// Heap and sequencer state.
	logic [CNT_W-1:0]  size_q;
	logic              tcancel_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  child_q;
	logic [POS_W-1:0]  idx_q;
	logic [ID_W-1:0]   cur_id_q;
	logic [TIME_W-1:0] cur_due_q;
	logic [ID_W-1:0]   cid_q;
	logic [TIME_W-1:0] cdue_q;
	logic [ID_W-1:0]   pid_q;
	logic              del_q;
	logic              moved_q;
	ret_t              ret_q;

	// Fired task details.
	logic [ID_W-1:0]   top_q;
	logic [TIME_W-1:0] tdue_q;
	logic [TIME_W-1:0] tper_q;
	logic              tfix_q;

	// Result fields.
	status_t           rstat_q;
	logic [ID_W-1:0]   rfired_q;
	logic [TIME_W-1:0] rftime_q;
	logic [TIME_W-1:0] rwait_q;
	logic              purged_q;
	logic [CNT_W-1:0]  removed_q;

	// Memory ports and shared adder.
	logic              h_we;
	logic [AW-1:0]     h_waddr;
	logic [ID_W-1:0]   h_wdata;
	logic [AW-1:0]     h_raddr;
	logic [ID_W-1:0]   h_rdata;
	task_wr_t          t_wr;
	logic [ID_W-1:0]   t_raddr;
	task_rd_t          t_rd;
	logic [TIME_W-1:0] alu_a;
	logic [TIME_W-1:0] alu_b;
	logic              alu_sub;
	logic [TIME_W:0]   alu_res;

	logic [POS_W-1:0]  parent;
	logic [POS_W-1:0]  child;
	logic [POS_W-1:0]  size_pos;
	logic [POS_W-1:0]  last_pos;
	logic              out_free;
	logic              in_acc;

	assign parent   = (pos_q - 1'b1) >> 1;
	assign child    = {pos_q[POS_W-2:0], 1'b1};
	assign size_pos = POS_W'(size_q);
	assign last_pos = size_pos - 1'b1;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc   = s_axis_tvalid && s_axis_tready;

	ttq_heap_mem #(
		.MAX_TASKS(MAX_TASKS),
		.AW       (AW)
	) u_heap (
		.clk  (clk),
		.we   (h_we),
		.waddr(h_waddr),
		.wdata(h_wdata),
		.raddr(h_raddr),
		.rdata(h_rdata)
	);

	ttq_task_mem u_task (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (t_wr),
		.raddr (t_raddr),
		.rd    (t_rd)
	);

	ttq_alu u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.sub(alu_sub),
		.res(alu_res)
	);

	// Operand selection of the shared adder.
	always_comb begin
		alu_a   = cur_due_q;
		alu_b   = cdue_q;
		alu_sub = 1'b1;
		case (state_q)
			S_SCH_CHK: begin
				alu_a   = now_q;
				alu_b   = delay_q;
				alu_sub = 1'b0;
			end
			S_POLL_ST: begin
				alu_a = t_rd.due;
				alu_b = now_q;
			end
			S_POLL_RE: begin
				alu_a   = tfix_q ? tdue_q : now_q;
				alu_b   = tper_q;
				alu_sub = 1'b0;
			end
			S_UP_CMP: begin
				alu_a = cur_due_q;
				alu_b = t_rd.due;
			end
			S_DN_D2: begin
				alu_a = t_rd.due;
				alu_b = cdue_q;
			end
			default: begin
				alu_a   = cur_due_q;
				alu_b   = cdue_q;
				alu_sub = 1'b1;
			end
		endcase
	end

	// Memory addresses and writes.
	always_comb begin
		h_we        = 1'b0;
		h_waddr     = AW'(pos_q);
		h_wdata     = cur_id_q;
		h_raddr     = '0;
		t_raddr     = id_q;
		t_wr        = '0;
		t_wr.waddr  = id_q;
		t_wr.due    = alu_res[TIME_W-1:0];
		t_wr.period = period_q;
		t_wr.fixed  = fixed_q;
		t_wr.stat   = TS_SCHED;
		case (state_q)
			S_DISP: begin
				if (op_q == OP_CANCEL && 32'(id_q) < 32'(MAX_TASKS)) begin
					t_wr.stat_we = 1'b1;
					t_wr.stat    = TS_CANCEL;
				end
			end
			S_SCH_CHK: begin
				if (!(32'(id_q) >= 32'(MAX_TASKS) || alu_res[TIME_W])
						&& t_rd.stat == TS_FRESH
						&& 32'(size_q) < 32'(MAX_TASKS)) begin
					t_wr.due_we  = 1'b1;
					t_wr.cfg_we  = 1'b1;
					t_wr.stat_we = 1'b1;
				end
			end
			S_POLL_ID: begin
				t_raddr = h_rdata;
			end
			S_POLL_RE: begin
				t_wr.waddr = top_q;
				if (tper_q != '0) begin
					t_wr.due_we = 1'b1;
					t_wr.due    = alu_res[TIME_W] ? {TIME_W{1'b1}} : alu_res[TIME_W-1:0];
				end else begin
					t_wr.stat_we = 1'b1;
					t_wr.stat    = TS_FINISHED;
				end
			end
			S_PURGE_CHK: h_raddr = AW'(idx_q);
			S_PURGE_ID:  t_raddr = h_rdata;
			S_DEL_START: h_raddr = AW'(last_pos);
			S_DEL_ID:    t_raddr = h_rdata;
			S_UP_CHK: begin
				h_raddr = AW'(parent);
				if (pos_q == '0 && !(del_q && !moved_q)) begin
					h_we = 1'b1;
				end
			end
			S_UP_PID: t_raddr = h_rdata;
			S_UP_CMP: begin
				if (alu_res[TIME_W]) begin
					h_we    = 1'b1;
					h_wdata = pid_q;
				end else if (!(del_q && !moved_q)) begin
					h_we = 1'b1;
				end
			end
			S_DN_CHK: begin
				h_raddr = AW'(child);
				if (child >= size_pos) begin
					h_we = 1'b1;
				end
			end
			S_DN_C1: t_raddr = h_rdata;
			S_DN_D1: h_raddr = AW'(child_q + 1'b1);
			S_DN_C2: t_raddr = h_rdata;
			S_DN_CMP: begin
				h_we = 1'b1;
				if (!alu_res[TIME_W]) begin
					h_wdata = cid_q;
				end
			end
			default: begin
				h_we = 1'b0;
			end
		endcase
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			size_q        <= '0;
			tcancel_q     <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			// The output register loads a new result or drains on acceptance.
			if (state_q == S_RESULT && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (op_q)
						OP_SCHEDULE: state_q <= tcancel_q ? S_RESULT : S_SCH_CHK;
						OP_POLL:     state_q <= tcancel_q ? S_RESULT : S_POLL_TOP;
						OP_PURGE:    state_q <= S_PURGE_CHK;
						OP_CANCEL_T: begin
							tcancel_q <= 1'b1;
							size_q    <= '0;
							state_q   <= S_RESULT;
						end
						default:     state_q <= S_RESULT;
					endcase
				end
				S_SCH_CHK: begin
					if (32'(id_q) >= 32'(MAX_TASKS) || alu_res[TIME_W]
							|| t_rd.stat != TS_FRESH
							|| 32'(size_q) >= 32'(MAX_TASKS)) begin
						state_q <= S_RESULT;
					end else begin
						size_q  <= size_q + 1'b1;
						state_q <= S_UP_CHK;
					end
				end
				S_POLL_TOP: state_q <= (size_q == '0) ? S_RESULT : S_POLL_ID;
				S_POLL_ID:  state_q <= S_POLL_ST;
				S_POLL_ST: begin
					if (t_rd.stat == TS_CANCEL) begin
						state_q <= S_DEL_START;
					end else if (alu_res[TIME_W] || alu_res == '0) begin
						state_q <= S_DEL_START;
					end else begin
						state_q <= S_RESULT;
					end
				end
				S_POLL_RE: begin
					if (tper_q != '0) begin
						size_q  <= size_q + 1'b1;
						state_q <= S_UP_CHK;
					end else begin
						state_q <= S_RESULT;
					end
				end
				S_PURGE_CHK: state_q <= (idx_q < size_pos) ? S_PURGE_ID : S_RESULT;
				S_PURGE_ID:  state_q <= S_PURGE_ST;
				S_PURGE_ST:  state_q <= (t_rd.stat == TS_CANCEL) ? S_DEL_START : S_PURGE_CHK;
				S_DEL_START: begin
					size_q  <= size_q - 1'b1;
					state_q <= (pos_q >= last_pos) ? S_FIN : S_DEL_ID;
				end
				S_DEL_ID:  state_q <= S_DEL_DUE;
				S_DEL_DUE: state_q <= S_UP_CHK;
				S_UP_CHK: begin
					if (pos_q != '0) begin
						state_q <= S_UP_PID;
					end else begin
						state_q <= (del_q && !moved_q) ? S_DN_CHK : S_FIN;
					end
				end
				S_UP_PID: state_q <= S_UP_CMP;
				S_UP_CMP: begin
					if (alu_res[TIME_W]) begin
						state_q <= S_UP_CHK;
					end else begin
						state_q <= (del_q && !moved_q) ? S_DN_CHK : S_FIN;
					end
				end
				S_DN_CHK: state_q <= (child < size_pos) ? S_DN_C1 : S_FIN;
				S_DN_C1:  state_q <= S_DN_D1;
				S_DN_D1:  state_q <= (child_q + 1'b1 < size_pos) ? S_DN_C2 : S_DN_CMP;
				S_DN_C2:  state_q <= S_DN_D2;
				S_DN_D2:  state_q <= S_DN_CMP;
				S_DN_CMP: state_q <= alu_res[TIME_W] ? S_FIN : S_DN_CHK;
				S_FIN: begin
					case (ret_q)
						RET_POLLDROP: state_q <= S_POLL_TOP;
						RET_POLLFIRE: state_q <= S_POLL_RE;
						RET_PURGE:    state_q <= S_PURGE_CHK;
						default:      state_q <= S_RESULT;
					endcase
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					op_q     <= s_axis_tdata[2:0];
					id_q     <= s_axis_tdata[10:3];
					now_q    <= s_axis_tdata[73:11];
					delay_q  <= s_axis_tdata[136:74];
					period_q <= s_axis_tdata[199:137];
					fixed_q  <= s_axis_tdata[200];
				end
			end
			S_DISP: begin
				rstat_q   <= ST_DONE;
				rfired_q  <= '0;
				rftime_q  <= '0;
				rwait_q   <= '0;
				purged_q  <= 1'b0;
				removed_q <= '0;
				idx_q     <= '0;
				case (op_q)
					OP_SCHEDULE: if (tcancel_q) rstat_q <= ST_BADSTATE;
					OP_POLL:     if (tcancel_q) rstat_q <= ST_BADSTATE;
					OP_CANCEL:   if (32'(id_q) >= 32'(MAX_TASKS)) rstat_q <= ST_BADARG;
					OP_PURGE:    purged_q <= 1'b1;
					OP_CANCEL_T: rstat_q <= ST_DONE;
					default:     rstat_q <= ST_BADARG;
				endcase
			end
			S_SCH_CHK: begin
				if (32'(id_q) >= 32'(MAX_TASKS) || alu_res[TIME_W]) begin
					rstat_q <= ST_BADARG;
				end else if (t_rd.stat != TS_FRESH) begin
					rstat_q <= ST_BADSTATE;
				end else if (32'(size_q) >= 32'(MAX_TASKS)) begin
					rstat_q <= ST_FULL;
				end
				cur_id_q  <= id_q;
				cur_due_q <= alu_res[TIME_W-1:0];
				pos_q     <= size_pos;
				del_q     <= 1'b0;
				moved_q   <= 1'b0;
				ret_q     <= RET_SCHED;
			end
			S_POLL_TOP: begin
				if (size_q == '0) begin
					rstat_q <= ST_EMPTY;
				end
			end
			S_POLL_ID: top_q <= h_rdata;
			S_POLL_ST: begin
				pos_q  <= '0;
				tdue_q <= t_rd.due;
				tper_q <= t_rd.period;
				tfix_q <= t_rd.fixed;
				if (t_rd.stat == TS_CANCEL) begin
					ret_q <= RET_POLLDROP;
				end else if (alu_res[TIME_W] || alu_res == '0) begin
					rstat_q  <= ST_FIRED;
					rfired_q <= top_q;
					rftime_q <= t_rd.due;
					ret_q    <= RET_POLLFIRE;
				end else begin
					rstat_q  <= ST_NOTDUE;
					rfired_q <= top_q;
					rwait_q  <= alu_res[TIME_W-1:0];
				end
			end
			S_POLL_RE: begin
				cur_id_q  <= top_q;
				cur_due_q <= alu_res[TIME_W] ? {TIME_W{1'b1}} : alu_res[TIME_W-1:0];
				pos_q     <= size_pos;
				del_q     <= 1'b0;
				moved_q   <= 1'b0;
				ret_q     <= RET_REINS;
			end
			S_PURGE_ST: begin
				if (t_rd.stat == TS_CANCEL) begin
					removed_q <= removed_q + 1'b1;
					pos_q     <= idx_q;
					ret_q     <= RET_PURGE;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_DEL_ID: cur_id_q <= h_rdata;
			S_DEL_DUE: begin
				cur_due_q <= t_rd.due;
				del_q     <= 1'b1;
				moved_q   <= 1'b0;
			end
			S_UP_PID: pid_q <= h_rdata;
			S_UP_CMP: begin
				if (alu_res[TIME_W]) begin
					pos_q   <= parent;
					moved_q <= 1'b1;
				end
			end
			S_DN_CHK: child_q <= child;
			S_DN_C1:  cid_q   <= h_rdata;
			S_DN_D1:  cdue_q  <= t_rd.due;
			S_DN_C2:  pid_q   <= h_rdata;
			S_DN_D2: begin
				if (alu_res[TIME_W]) begin
					cid_q   <= pid_q;
					cdue_q  <= t_rd.due;
					child_q <= child_q + 1'b1;
				end
			end
			S_DN_CMP: begin
				if (!alu_res[TIME_W]) begin
					pos_q <= child_q;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					m_axis_tdata <= {6'b0, purged_q ? removed_q : size_q,
						rwait_q, rftime_q, rfired_q, rstat_q};
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

endmodule

@@ sv/ttq_alu.sv @@
// ----------------------------------------------------------------------------
// Timer queue shared adder
// One 63-bit add/subtract unit used for all time sums and compares.
// Bit 63 of the result is the carry of an add or the borrow of a subtract.
// ----------------------------------------------------------------------------
module ttq_alu
	import ttq_pkg::*;
(
	input  logic [TIME_W-1:0] a,
	input  logic [TIME_W-1:0] b,
	input  logic              sub,
	output logic [TIME_W:0]   res
);

	logic [TIME_W:0] b_ext;

	// Two's complement subtract through the same adder.
	assign b_ext = sub ? ~{1'b0, b} : {1'b0, b};
	assign res   = {1'b0, a} + b_ext + {{TIME_W{1'b0}}, sub};

endmodule

@@ sv/ttq_heap_mem.sv @@
// ----------------------------------------------------------------------------
// Timer queue heap memory
// Task ids by heap position, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ttq_heap_mem
	import ttq_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF,
	parameter int AW        = $clog2(MAX_TASKS)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  logic [ID_W-1:0] wdata,
	input  logic [AW-1:0]   raddr,
	output logic [ID_W-1:0] rdata
);

	logic [ID_W-1:0] mem [MAX_TASKS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ sv/ttq_task_mem.sv @@
// ----------------------------------------------------------------------------
// Timer queue task table
// Due time, period, mode and status per task slot. Status entries carry
// valid bits so that an unwritten slot reads as fresh after reset.
// ----------------------------------------------------------------------------
module ttq_task_mem
	import ttq_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  task_wr_t        wr,
	input  logic [ID_W-1:0] raddr,
	output task_rd_t        rd
);

	logic [TIME_W-1:0] due_mem [TASK_SLOTS];
	logic [TIME_W-1:0] per_mem [TASK_SLOTS];
	logic              fix_mem [TASK_SLOTS];
	tstat_t            stat_mem [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] valid_q;
	tstat_t            stat_rd;
	logic              valid_rd;

	// Table writes.
	always_ff @(posedge clk) begin
		if (wr.due_we) begin
			due_mem[wr.waddr] <= wr.due;
		end
		if (wr.cfg_we) begin
			per_mem[wr.waddr] <= wr.period;
			fix_mem[wr.waddr] <= wr.fixed;
		end
		if (wr.stat_we) begin
			stat_mem[wr.waddr] <= wr.stat;
		end
	end

	// Valid bits of the status entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.stat_we) begin
			valid_q[wr.waddr] <= 1'b1;
		end
	end

	// Registered reads.
	always_ff @(posedge clk) begin
		rd.due    <= due_mem[raddr];
		rd.period <= per_mem[raddr];
		rd.fixed  <= fix_mem[raddr];
		stat_rd   <= stat_mem[raddr];
		valid_rd  <= valid_q[raddr];
	end

	// A slot never written is fresh.
	assign rd.stat = valid_rd ? stat_rd : TS_FRESH;

endmodule

@@ test/timer_task_heap_scheduler_test.sv @@
// ----------------------------------------------------------------------------
// Timer task heap scheduler testbench
// Drives command transactions through the stream input, predicts every result
// with a behavioral heap model and compares the results field by field.
// ----------------------------------------------------------------------------
module timer_task_heap_scheduler_test
	import ttq_pkg::*;
;

	localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};
	localparam int IDLE_LIMIT = 200000;

	typedef struct packed {
		logic [2:0]        op;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] delay;
		logic [TIME_W-1:0] period;
		logic              fixed;
	} cmd_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [ID_W-1:0]   fired;
		logic [TIME_W-1:0] ftime;
		logic [TIME_W-1:0] wait_t;
		logic [CNT_W-1:0]  count;
	} res_t;

	// Directed stimulus row; has_res marks a typed-in expected result.
	typedef struct {
		cmd_t cmd;
		bit   has_res;
		res_t res;
	} row_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;

	timer_task_heap_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Predictor state.
	logic [ID_W-1:0]   hp_ids [TASK_SLOTS];
	int                hp_size;
	logic [TIME_W:0]   tk_due [TASK_SLOTS];
	logic [TIME_W-1:0] tk_period [TASK_SLOTS];
	logic              tk_fixed [TASK_SLOTS];
	tstat_t            tk_stat [TASK_SLOTS];
	bit                timer_dead;

	res_t expected_results [$];
	int   mismatches = 0;
	int   table_errs = 0;
	int   idle_cycles = 0;

	initial begin
		clk = 1'b0;
	end
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [IN_W-1:0] pack_cmd(cmd_t c);
		logic [IN_W-1:0] v;
		v = '0;
		v[2:0] = c.op;
		v[10:3] = c.id;
		v[73:11] = c.now;
		v[136:74] = c.delay;
		v[199:137] = c.period;
		v[200] = c.fixed;
		return v;
	endfunction

	function automatic logic [TIME_W:0] due_of(int pos);
		return tk_due[hp_ids[pos]];
	endfunction

	function automatic int heap_rise(int pos);
		int parent;
		logic [ID_W-1:0] t;
		while (pos > 0) begin
			parent = (pos - 1) / 2;
			if (due_of(pos) < due_of(parent)) begin
				t = hp_ids[pos]; hp_ids[pos] = hp_ids[parent]; hp_ids[parent] = t;
				pos = parent;
			end else begin
				break;
			end
		end
		return pos;
	endfunction

	function automatic void heap_sink(int pos);
		int child;
		logic [ID_W-1:0] t;
		child = 2 * pos + 1;
		while (child < hp_size) begin
			if (child + 1 < hp_size && due_of(child + 1) < due_of(child))
				child++;
			if (due_of(pos) < due_of(child))
				break;
			t = hp_ids[pos]; hp_ids[pos] = hp_ids[child]; hp_ids[child] = t;
			pos = child;
			child = 2 * pos + 1;
		end
	endfunction

	function automatic void heap_remove(int pos);
		if (pos >= hp_size)
			return;
		hp_size--;
		hp_ids[pos] = hp_ids[hp_size];
		if (pos < hp_size) begin
			if (heap_rise(pos) == pos)
				heap_sink(pos);
		end
	endfunction

	function automatic void heap_add(logic [ID_W-1:0] id);
		hp_ids[hp_size] = id;
		hp_size++;
		void'(heap_rise(hp_size - 1));
	endfunction

	function automatic void timer_reset();
		hp_size = 0;
		timer_dead = 0;
		for (int i = 0; i < TASK_SLOTS; i++)
			tk_stat[i] = TS_FRESH;
	endfunction

	// Computes the result of one command and advances the predictor state.
	function automatic res_t timer_step(cmd_t c);
		res_t r;
		int removed, i;
		logic [ID_W-1:0] top;
		logic [TIME_W:0] due, nd;
		bit purged;
		r = '0;
		r.status = ST_DONE;
		purged = 0;
		removed = 0;
		case (c.op)
			OP_SCHEDULE: begin
				if (timer_dead)
					r.status = ST_BADSTATE;
				else if ({1'b0, c.now} + {1'b0, c.delay} > {1'b0, TMAX})
					r.status = ST_BADARG;
				else if (tk_stat[c.id] != TS_FRESH)
					r.status = ST_BADSTATE;
				else if (hp_size >= TASK_SLOTS)
					r.status = ST_FULL;
				else begin
					tk_due[c.id] = {1'b0, c.now} + {1'b0, c.delay};
					tk_period[c.id] = c.period;
					tk_fixed[c.id] = c.fixed;
					tk_stat[c.id] = TS_SCHED;
					heap_add(c.id);
				end
			end
			OP_POLL: begin
				if (timer_dead) begin
					r.status = ST_BADSTATE;
				end else begin
					while (hp_size > 0 && tk_stat[hp_ids[0]] == TS_CANCEL)
						heap_remove(0);
					if (hp_size == 0) begin
						r.status = ST_EMPTY;
					end else begin
						top = hp_ids[0];
						due = tk_due[top];
						r.fired = top;
						if (due > {1'b0, c.now}) begin
							r.status = ST_NOTDUE;
							r.wait_t = TIME_W'(due - {1'b0, c.now});
						end else begin
							r.status = ST_FIRED;
							r.ftime = TIME_W'(due);
							heap_remove(0);
							if (tk_period[top] != 0) begin
								nd = (tk_fixed[top] ? due : {1'b0, c.now})
									+ {1'b0, tk_period[top]};
								if (nd > {1'b0, TMAX})
									nd = {1'b0, TMAX};
								tk_due[top] = nd;
								heap_add(top);
							end else begin
								tk_stat[top] = TS_FINISHED;
							end
						end
					end
				end
			end
			OP_CANCEL: tk_stat[c.id] = TS_CANCEL;
			OP_PURGE: begin
				purged = 1;
				i = 0;
				while (i < hp_size) begin
					if (tk_stat[hp_ids[i]] == TS_CANCEL) begin
						removed++;
						heap_remove(i);
					end else begin
						i++;
					end
				end
			end
			OP_CANCEL_T: begin
				timer_dead = 1;
				hp_size = 0;
			end
			default: r.status = ST_BADARG;
		endcase
		r.count = purged ? CNT_W'(removed) : CNT_W'(hp_size);
		return r;
	endfunction

	// Receiver: stall pattern and result checking.
	int stall_phase = 0;
	always @(posedge clk) begin
		res_t got, exp_r;
		if (arst_n) begin
			stall_phase <= stall_phase + 1;
			if ((stall_phase % 37) < 20)
				m_axis_tready <= 1'b1;
			else
				m_axis_tready <= ($urandom_range(0, 2) != 0);
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tdata[73:11],
					m_axis_tdata[136:74], m_axis_tdata[145:137]};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transaction %h", got);
				end else begin
					exp_r = expected_results.pop_front();
					if (got !== exp_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: st %0d/%0d id %0d/%0d ft %0d/%0d wt %0d/%0d cnt %0d/%0d",
								exp_r.status, got.status, exp_r.fired, got.fired,
								exp_r.ftime, got.ftime, exp_r.wait_t, got.wait_t,
								exp_r.count, got.count);
					end
				end
			end
		end
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	int burst_left;

	// Sends one command, honoring the burst and gap pattern.
	task automatic send_cmd(cmd_t c, bit has_res, res_t res);
		res_t pred;
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pack_cmd(c);
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pred = timer_step(c);
		if (has_res && pred !== res) begin
			table_errs++;
			if (table_errs <= 10)
				$display("predictor disagrees with table row: %h vs %h", pred, res);
		end
		expected_results.push_back(has_res ? res : pred);
		if (burst_left == 0)
			s_axis_tvalid <= 1'b0;
	endtask

	function automatic logic [TIME_W-1:0] rand_time(int small_cap);
		logic [TIME_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = TIME_W'({$urandom, $urandom});
			1: v = TMAX - TIME_W'($urandom_range(0, 100));
			default: v = TIME_W'($urandom_range(0, small_cap));
		endcase
		return v;
	endfunction

	function automatic cmd_t mk(logic [2:0] op, int id, logic [TIME_W-1:0] now,
		logic [TIME_W-1:0] dl, logic [TIME_W-1:0] per, bit fx);
		cmd_t c;
		c.op = op; c.id = ID_W'(id); c.now = now; c.delay = dl; c.period = per;
		c.fixed = fx;
		return c;
	endfunction

	function automatic res_t rs(status_t st, int cnt);
		res_t r;
		r = '0; r.status = st; r.count = CNT_W'(cnt);
		return r;
	endfunction

	row_t rows [$];
	logic [TIME_W-1:0] clock_ms;

	initial begin
		cmd_t c;
		res_t nores;
		int pick;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		burst_left = 0;
		nores = '0;
		timer_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty poll, extremes, bad args, then predicted rows.
		rows.push_back('{mk(OP_POLL, 0, 0, 0, 0, 0), 1, rs(ST_EMPTY, 0)});
		rows.push_back('{mk(OP_PURGE, 0, 0, 0, 0, 0), 1, rs(ST_DONE, 0)});
		rows.push_back('{mk(3'd5, 0, 0, 0, 0, 0), 1, rs(ST_BADARG, 0)});
		rows.push_back('{mk(3'd7, 255, TMAX, TMAX, TMAX, 1), 1, rs(ST_BADARG, 0)});
		rows.push_back('{mk(OP_SCHEDULE, 1, TMAX, 1, 0, 0), 1, rs(ST_BADARG, 0)});
		rows.push_back('{mk(OP_SCHEDULE, 1, TMAX, 0, TMAX, 1), 1, rs(ST_DONE, 1)});
		rows.push_back('{mk(OP_SCHEDULE, 1, 0, 0, 0, 0), 1, rs(ST_BADSTATE, 1)});
		rows.push_back('{mk(OP_SCHEDULE, 0, 0, 10, 0, 0), 0, nores});
		rows.push_back('{mk(OP_SCHEDULE, 255, 5, 5, 7, 0), 0, nores});
		rows.push_back('{mk(OP_SCHEDULE, 2, 0, 10, 3, 1), 0, nores});
		rows.push_back('{mk(OP_POLL, 0, 3, 0, 0, 0), 0, nores});
		rows.push_back('{mk(OP_POLL, 0, 10, 0, 0, 0), 0, nores});
		rows.push_back('{mk(OP_POLL, 0, 10, 0, 0, 0), 0, nores});
		rows.push_back('{mk(OP_POLL, 0, 12, 0, 0, 0), 0, nores});
		rows.push_back('{mk(OP_CANCEL, 2, 0, 0, 0, 0), 0, nores});
		rows.push_back('{mk(OP_CANCEL, 200, 0, 0, 0, 0), 0, nores});
		rows.push_back('{mk(OP_POLL, 0, 30, 0, 0, 0), 0, nores});
		rows.push_back('{mk(OP_CANCEL, 255, 0, 0, 0, 0), 0, nores});
		rows.push_back('{mk(OP_PURGE, 0, 0, 0, 0, 0), 0, nores});
		rows.push_back('{mk(OP_POLL, 0, TMAX, 0, 0, 0), 0, nores});
		rows.push_back('{mk(OP_POLL, 0, TMAX, 0, 0, 0), 0, nores});
		foreach (rows[i])
			send_cmd(rows[i].cmd, rows[i].has_res, rows[i].res);

		// Schedule every task slot to load the heap deeply.
		for (int i = 0; i < TASK_SLOTS; i++)
			send_cmd(mk(OP_SCHEDULE, i, 100, TIME_W'($urandom_range(0, 1000)),
				$urandom_range(0, 1) ? TIME_W'($urandom_range(1, 50)) : '0,
				1'($urandom_range(0, 1))),
				0, nores);
		send_cmd(mk(OP_POLL, 0, 2000, 0, 0, 0), 0, nores);
		send_cmd(mk(OP_SCHEDULE, 3, 0, 0, 0, 0), 0, nores);

		// Random traffic: mostly polls with advancing time, cancels and purges.
		clock_ms = 2000;
		for (int n = 0; n < 1210; n++) begin
			pick = $urandom_range(0, 99);
			clock_ms = clock_ms + TIME_W'($urandom_range(0, 40));
			if (pick < 55)
				c = mk(OP_POLL, $urandom, clock_ms, TIME_W'({$urandom, $urandom}),
					TIME_W'({$urandom, $urandom}), 1'($urandom_range(0, 1)));
			else if (pick < 75)
				c = mk(OP_CANCEL, $urandom, TIME_W'({$urandom, $urandom}), 0, 0, 0);
			else if (pick < 85)
				c = mk(OP_PURGE, $urandom, 0, 0, 0, 1'($urandom_range(0, 1)));
			else if (pick < 97)
				c = mk(OP_SCHEDULE, $urandom, clock_ms, rand_time(300), rand_time(60),
					1'($urandom_range(0, 1)));
			else
				c = mk(3'($urandom_range(5, 7)), $urandom, 0, 0, 0, 0);
			if (pick >= 97 && pick < 98 && n < 600)
				c = mk(OP_POLL, 0, rand_time(100000), 0, 0, 0);
			send_cmd(c, 0, nores);
		end

		// Cancelled timer: schedules and polls after it are refused.
		send_cmd(mk(OP_CANCEL_T, 0, 0, 0, 0, 0), 1, rs(ST_DONE, 0));
		for (int n = 0; n < 60; n++) begin
			pick = $urandom_range(0, 4);
			send_cmd(mk(3'(pick), $urandom, TIME_W'({$urandom, $urandom}),
				TIME_W'($urandom_range(0, 9)), TIME_W'($urandom),
				1'($urandom_range(0, 1))), 0, nores);
		end
		s_axis_tvalid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && table_errs == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
